// File: rtl/core/bfms_pkg.sv
// Shared constants, types and helpers for the blurred-frame motion SAD unit.
// Depends on nothing; imported by blurred_frame_motion_sad_unit.
package bfms_pkg;

   localparam int TAPS            = 5;
   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int MAX_HEIGHT_DEF  = 2048;
   localparam int PIX_W           = 10;
   localparam int BLUR_W          = 15;
   localparam int COEF_W          = 14;
   localparam int SAD_W           = 37;
   localparam int ACC_W           = 38;
   localparam int CFG_W           = 12;
   localparam int CSR_IDX_W       = 2;
   localparam int H_SHIFT         = 15;
   localparam int MIN_SIZE        = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEN_BIT_MODE = 2'd2;

   localparam logic [COEF_W-1:0] KERNEL [TAPS] = '{14'd1785, 14'd8002, 14'd13193,
                                                   14'd8002, 14'd1785};

   // One issued step of the blur datapath.
   typedef struct packed {
      logic             pix;   // raw pixel, update line store
      logic             vert;  // produces a vertical blur sample
      logic             hout;  // produces a blurred output sample
      logic             fin;   // last output sample of the frame
      logic             ten;   // 10-bit mode of this frame
      logic [PIX_W-1:0] px;
      logic [TAPS-1:0][2:0] vd;  // vertical tap age (0 = newest row)
      logic [TAPS-1:0][2:0] hd;  // horizontal tap age (0 = newest column)
   } op_type;

   // Age of mirrored tap k around center, given the newest index present.
   function automatic logic [2:0] tap_dist(input logic signed [15:0] newest,
                                           input logic signed [15:0] center,
                                           input logic signed [15:0] size,
                                           input int k);
      logic signed [15:0] p;
      logic signed [15:0] d;
      p = center + 16'(k) - 16'sd2;
      if (p < 0) p = -p;
      if (p >= size) p = (size <<< 1) - 16'sd1 - p;
      d = newest - p;
      return d[2:0];
   endfunction

   function automatic logic [15:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
      logic [15:0] r;
      r = 16'(v);
      if (r < 16'(MIN_SIZE)) r = 16'(MIN_SIZE);
      else if (r > 16'(maxv)) r = 16'(maxv);
      return r;
   endfunction

endpackage

// File: rtl/core/blurred_frame_motion_sad_unit.sv
// Blurred-frame motion SAD: 5-tap separable blur of each frame and SAD against
// the previous blurred frame. Depends on bfms_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid req_ready req_pixel_value     | in, one raster pixel per transfer
//  rsp     | rsp_valid rsp_ready rsp_frame_sad/first | out, one result per frame
//  csr     | csr_valid csr_ready csr_index csr_data  | in, register write, always ready
//
// One pixel per cycle while a row streams in. After each row from the third on,
// the states ST_HF1 and ST_HF2 finish the right border of the blurred row; after
// the last row, two more rows in state ST_VF, each followed by ST_HF1 and ST_HF2,
// finish the bottom border from the line store. The result is registered after
// the last step passes pipeline stages A to E. The line store and the frame store
// are single-ported registered reads and need no clearing after reset. The last
// step of a frame waits while the previous result is untaken.
module blurred_frame_motion_sad_unit
   import bfms_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAD_W-1:0]     rsp_frame_sad,
   output logic                 rsp_first_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWW = $clog2(MAX_WIDTH + 1);
   localparam int SHW = $clog2(MAX_HEIGHT + 1);
   localparam int VSUM_W = 25;
   localparam int HSUM_W = 30;
   localparam int VPROD_W = COEF_W + PIX_W;
   localparam int HPROD_W = COEF_W + BLUR_W;

   localparam logic [1:0] ST_PIX = 2'd0;
   localparam logic [1:0] ST_HF1 = 2'd1;
   localparam logic [1:0] ST_HF2 = 2'd2;
   localparam logic [1:0] ST_VF  = 2'd3;

   // configuration
   logic [CFG_W-1:0] cfg_w_ff, cfg_h_ff;
   logic             cfg_ten_ff;
   logic [SWW-1:0]   cur_w_ff;
   logic [SHW-1:0]   cur_h_ff;
   logic             cur_ten_ff;

   // sequencer
   logic [1:0]    st_ff, st_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          vf_ff, vf_in;

   // memories
   logic [TAPS-1:1][PIX_W-1:0] raw_mem [MAX_WIDTH];
   logic [TAPS-1:1][PIX_W-1:0] raw_q_ff;
   logic [BLUR_W-1:0]          prev_mem [2**(RW+CW)];
   logic [BLUR_W-1:0]          prev_q_ff;

   // pipeline
   op_type        op, a_op_ff, b_op_ff, c_op_ff, d_op_ff;
   logic          a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW+CW-1:0] op_addr, a_addr_ff, b_addr_ff, c_addr_ff, d_addr_ff, e_addr_ff;
   logic [TAPS-1:0][VPROD_W-1:0] vprod_ff;
   logic [TAPS-1:0][HPROD_W-1:0] hprod_ff;
   logic [TAPS-1:0][BLUR_W-1:0]  win_ff;
   logic [BLUR_W-1:0] eb_ff, ep_ff;
   logic          e_fin_ff;
   logic [ACC_W-1:0] acc_ff;
   logic          seen_ff;
   logic          rsp_valid_ff;
   logic [SAD_W-1:0] rsp_sad_ff;
   logic          rsp_first_ff;

   // front-end combinational
   logic          first_px;
   logic [15:0]   w_clamp, h_clamp;
   logic [SWW-1:0] eff_w;
   logic [SHW-1:0] eff_h;
   logic          eff_ten;
   logic          is_hf, from_vf, issue;
   logic [RW-1:0] out_row, last_row;
   logic [CW-1:0] out_col, last_col;
   logic signed [15:0] nv, nc;

   assign csr_ready = 1'b1;
   assign w_clamp   = clamp_size(cfg_w_ff, MAX_WIDTH);
   assign h_clamp   = clamp_size(cfg_h_ff, MAX_HEIGHT);
   assign first_px  = (st_ff == ST_PIX) && (row_ff == '0) && (col_ff == '0);
   assign eff_w     = first_px ? SWW'(w_clamp) : cur_w_ff;
   assign eff_h     = first_px ? SHW'(h_clamp) : cur_h_ff;
   assign eff_ten   = first_px ? cfg_ten_ff : cur_ten_ff;
   assign last_col  = CW'(eff_w - SWW'(1));
   assign last_row  = RW'(eff_h - SHW'(1));

   always_comb begin
      is_hf   = (st_ff == ST_HF1) || (st_ff == ST_HF2);
      from_vf = (st_ff == ST_VF) || (is_hf && vf_ff);
      out_row = from_vf ? row_ff : RW'(row_ff - RW'(2));
      nv      = from_vf ? 16'(last_row) : 16'(row_ff);
      if (is_hf) begin
         out_col = (st_ff == ST_HF1) ? CW'(eff_w - SWW'(2)) : last_col;
         nc      = 16'(last_col);
      end else begin
         out_col = CW'(col_ff - CW'(2));
         nc      = 16'(col_ff);
      end
      op.pix  = (st_ff == ST_PIX);
      op.vert = ((st_ff == ST_PIX) && (row_ff >= RW'(2))) || (st_ff == ST_VF);
      op.hout = is_hf || (op.vert && (col_ff >= CW'(2)));
      op.fin  = (st_ff == ST_HF2) && vf_ff && (row_ff == last_row);
      op.ten  = eff_ten;
      op.px   = eff_ten ? req_pixel_value : {2'b00, req_pixel_value[7:0]};
      for (int k = 0; k < TAPS; k++) begin
         op.vd[k] = tap_dist(nv, 16'(out_row), 16'(eff_h), k);
         op.hd[k] = tap_dist(nc, 16'(out_col), 16'(eff_w), k);
      end
      op_addr = {out_row, out_col};
      req_ready = (st_ff == ST_PIX);
      issue = (st_ff == ST_PIX) ? req_valid : !(op.fin && rsp_valid_ff);
   end

   always_comb begin
      st_in  = st_ff;
      col_in = col_ff;
      row_in = row_ff;
      vf_in  = vf_ff;
      if (issue) begin
         case (st_ff)
            ST_PIX, ST_VF: begin
               if (col_ff == last_col) begin
                  col_in = '0;
                  if (op.vert) st_in = ST_HF1;
                  else row_in = RW'(row_ff + RW'(1));
               end else begin
                  col_in = CW'(col_ff + CW'(1));
               end
            end
            ST_HF1: st_in = ST_HF2;
            ST_HF2: begin
               if (vf_ff) begin
                  if (row_ff == last_row) begin
                     st_in  = ST_PIX;
                     row_in = '0;
                     vf_in  = 1'b0;
                  end else begin
                     st_in  = ST_VF;
                     row_in = RW'(row_ff + RW'(1));
                  end
               end else if (row_ff == last_row) begin
                  st_in  = ST_VF;
                  vf_in  = 1'b1;
                  row_in = RW'(eff_h - SHW'(2));
               end else begin
                  st_in  = ST_PIX;
                  row_in = RW'(row_ff + RW'(1));
               end
            end
            default: st_in = ST_PIX;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff   <= CFG_W'(2048);
         cfg_h_ff   <= CFG_W'(2048);
         cfg_ten_ff <= 1'b0;
         cur_w_ff   <= SWW'(MAX_WIDTH);
         cur_h_ff   <= SHW'(MAX_HEIGHT);
         cur_ten_ff <= 1'b0;
         st_ff      <= ST_PIX;
         col_ff     <= '0;
         row_ff     <= '0;
         vf_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_w_ff   <= csr_data;
               CSR_FRAME_HEIGHT: cfg_h_ff   <= csr_data;
               CSR_TEN_BIT_MODE: cfg_ten_ff <= csr_data[0];
               default: ;
            endcase
         end
         // latch frame geometry and bit mode on the first pixel
         if (issue && first_px) begin
            cur_w_ff   <= eff_w;
            cur_h_ff   <= eff_h;
            cur_ten_ff <= eff_ten;
         end
         st_ff  <= st_in;
         col_ff <= col_in;
         row_ff <= row_in;
         vf_ff  <= vf_in;
      end
   end

   // stage A: line store read, vertical products, store write-back
   logic [TAPS-1:0][PIX_W-1:0] vtap;
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         logic [2:0] sel;
         sel = a_op_ff.pix ? a_op_ff.vd[k] : 3'(a_op_ff.vd[k] + 3'd1);
         case (sel)
            3'd0:    vtap[k] = a_op_ff.px;
            3'd1:    vtap[k] = raw_q_ff[1];
            3'd2:    vtap[k] = raw_q_ff[2];
            3'd3:    vtap[k] = raw_q_ff[3];
            3'd4:    vtap[k] = raw_q_ff[4];
            default: vtap[k] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      raw_q_ff <= raw_mem[col_ff];
      if (a_vld_ff && a_op_ff.pix)
         raw_mem[a_col_ff] <= {raw_q_ff[3:1], a_op_ff.px};
      a_op_ff   <= op;
      a_col_ff  <= col_ff;
      a_addr_ff <= op_addr;
      for (int k = 0; k < TAPS; k++)
         vprod_ff[k] <= VPROD_W'(KERNEL[k] * vtap[k]);
      b_op_ff   <= a_op_ff;
      b_addr_ff <= a_addr_ff;
   end

   // stage B: vertical sum and shift into the horizontal window
   logic [VSUM_W-1:0] vsum;
   logic [BLUR_W-1:0] vval;
   always_comb begin
      vsum = '0;
      for (int k = 0; k < TAPS; k++) vsum = vsum + VSUM_W'(vprod_ff[k]);
      vval = b_op_ff.ten ? BLUR_W'(vsum >> 10) : BLUR_W'(vsum >> 8);
   end

   always_ff @(posedge clock) begin
      if (b_vld_ff && b_op_ff.vert) win_ff <= {win_ff[TAPS-2:0], vval};
      c_op_ff   <= b_op_ff;
      c_addr_ff <= b_addr_ff;
   end

   // stage C: horizontal products, previous frame read
   always_ff @(posedge clock) begin
      for (int k = 0; k < TAPS; k++)
         hprod_ff[k] <= HPROD_W'(KERNEL[k] * win_ff[c_op_ff.hd[k]]);
      prev_q_ff <= prev_mem[c_addr_ff];
      d_op_ff   <= c_op_ff;
      d_addr_ff <= c_addr_ff;
   end

   // stage D: horizontal sum
   logic [HSUM_W-1:0] hsum;
   always_comb begin
      hsum = '0;
      for (int k = 0; k < TAPS; k++) hsum = hsum + HSUM_W'(hprod_ff[k]);
   end

   always_ff @(posedge clock) begin
      eb_ff     <= BLUR_W'(hsum >> H_SHIFT);
      ep_ff     <= prev_q_ff;
      e_fin_ff  <= d_op_ff.fin;
      e_addr_ff <= d_addr_ff;
   end

   // stage E: absolute difference, accumulate, frame store write
   logic [BLUR_W-1:0] diff;
   logic [ACC_W-1:0]  acc_next;
   assign diff     = (eb_ff >= ep_ff) ? BLUR_W'(eb_ff - ep_ff) : BLUR_W'(ep_ff - eb_ff);
   assign acc_next = seen_ff ? ACC_W'(acc_ff + ACC_W'(diff)) : acc_ff;

   always_ff @(posedge clock) begin
      if (e_vld_ff) prev_mem[e_addr_ff] <= eb_ff;
      if (e_vld_ff && e_fin_ff) begin
         rsp_sad_ff   <= SAD_W'(acc_next);
         rsp_first_ff <= !seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff && c_op_ff.hout;
         e_vld_ff <= d_vld_ff;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (e_vld_ff) begin
            if (e_fin_ff) begin
               acc_ff       <= '0;
               seen_ff      <= 1'b1;
               rsp_valid_ff <= 1'b1;
            end else begin
               acc_ff <= acc_next;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_sad   = rsp_sad_ff;
   assign rsp_first_frame = rsp_first_ff;

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_first_ff |-> rsp_sad_ff == '0)
      else $error("first frame result carries a nonzero SAD");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      SWW'(col_ff) < cur_w_ff)
      else $error("column counter beyond frame width");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(e_vld_ff && e_fin_ff))
      else $error("result raised without a frame end");
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      e_vld_ff && e_fin_ff |=> acc_ff == '0)
      else $error("accumulator not cleared at frame end");

endmodule
